/* rtl/twt_pkg.sv */
`default_nettype none

package twt_pkg;

	// character codes the tokenizer reacts to
	localparam logic [7:0] CH_AMP    = 8'h26;  // &
	localparam logic [7:0] CH_APOS   = 8'h27;  // '
	localparam logic [7:0] CH_DASH   = 8'h2D;  // -
	localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
	localparam logic [7:0] CH_COLON  = 8'h3A;  // :
	localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
	localparam logic [7:0] CH_DOT    = 8'h2E;  // .
	localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
	localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
	localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
	localparam logic [7:0] CH_STAR   = 8'h2A;  // *
	localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
	localparam logic [7:0] CH_BANG   = 8'h21;  // !
	localparam logic [7:0] CH_QMARK  = 8'h3F;  // ?
	localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
	localparam logic [7:0] CH_RPAREN = 8'h29;  // )
	localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// config register indexes
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WILDCARD  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PARAGRAPH = 1'b1;
	localparam int unsigned CFG_DATA_BITS = 32;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_DIGIT = 2'd1;
	localparam logic [1:0] ERR_NO_COMMA  = 2'd2;

	// front-to-back queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = 2;

	// byte classes worked out in the front
	typedef struct packed {
		logic dig;       // 0-9
		logic alnum;     // letter or digit
		logic dot;
		logic comma;
		logic colon;
		logic bslash;
		logic lbrace;
		logic rbrace;
		logic wild;      // . \ * + ? {
		logic bang_q;    // ! or ?
		logic closer;    // ends a sentence after a dot
		logic gen_punct; // & ' - _
	} twt_class_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		twt_class_t cls;
	} twt_word_t;

endpackage

`default_nettype wire

/* rtl/twt_front.sv */
`default_nettype none

module twt_front import twt_pkg::*; (
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	output logic            in_stall,
	input  wire logic       q_full,
	output logic            push,
	output twt_word_t       push_word
);

	twt_class_t cls;

	always_comb begin
		cls.dig       = (in_byte inside {["0":"9"]});
		cls.alnum     = (in_byte inside {["0":"9"], ["A":"Z"], ["a":"z"]});
		cls.dot       = (in_byte == CH_DOT);
		cls.comma     = (in_byte == CH_COMMA);
		cls.colon     = (in_byte == CH_COLON);
		cls.bslash    = (in_byte == CH_BSLASH);
		cls.lbrace    = (in_byte == CH_LBRACE);
		cls.rbrace    = (in_byte == CH_RBRACE);
		cls.wild      = (in_byte inside {CH_DOT, CH_BSLASH, CH_STAR, CH_PLUS, CH_QMARK,
			CH_LBRACE});
		cls.bang_q    = (in_byte inside {CH_BANG, CH_QMARK});
		cls.closer    = (in_byte inside {CH_DQUOTE, CH_APOS, CH_RPAREN, CH_RBRACK, CH_RBRACE,
			CH_SPACE, [CH_TAB:CH_CR]});
		cls.gen_punct = (in_byte inside {CH_AMP, CH_APOS, CH_DASH, CH_UNDER});
	end

	assign in_stall       = q_full;
	assign push           = in_valid && !q_full;
	assign push_word.data = in_byte;
	assign push_word.last = last_byte;
	assign push_word.cls  = cls;

endmodule

`default_nettype wire

/* rtl/twt_queue.sv */
`default_nettype none

module twt_queue import twt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire twt_word_t  push_word,
	output logic            full,
	input  wire logic       pop,
	output twt_word_t       pop_word,
	output logic            empty
);

	twt_word_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;

	assign full     = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_BITS+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_BITS+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/twt_back.sv */
`default_nettype none

module twt_back import twt_pkg::*; #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     q_empty,
	input  wire twt_word_t                q_word,
	output logic                          q_pop,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic                          appended,
	output logic                          token_done,
	output logic [31:0]                   token_number,
	output logic [31:0]                   sentence_number,
	output logic [31:0]                   paragraph_out,
	output logic [1:0]                    error_code
);

	typedef enum logic [1:0] {KIND_GENERIC, KIND_INTEGER, KIND_DECIMAL, KIND_TIME} kind_t;
	typedef enum logic [1:0] {PH_OUT, PH_FIRST, PH_SECOND} phase_t;

	logic                  wildcard_q;
	logic [31:0]           paragraph_q;

	logic                  open_q, n_open;
	kind_t                 kind_q, n_kind, kind_c;
	logic                  esc_q, n_esc;
	logic                  awd_q, n_awd;
	phase_t                phase_q, n_phase;
	logic                  seen_q, n_seen;
	logic                  dot_q, n_dot;
	logic                  failed_q, n_failed;
	logic [COUNT_BITS-1:0] tok_cnt_q, n_tok_cnt;
	logic [COUNT_BITS-1:0] sent_cnt_q, n_sent_cnt;

	logic                  c_app, c_done, c_proc, c_cont;
	logic [1:0]            c_err;
	logic [COUNT_BITS-1:0] c_tok_rep, c_sent_rep;

	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  app_q, done_q;
	logic [31:0]           tok_q, sent_q, para_q;
	logic [1:0]            err_q;

	twt_class_t c;
	assign c = q_word.cls;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		n_open     = open_q;
		n_kind     = kind_q;
		n_esc      = esc_q;
		n_awd      = awd_q;
		n_phase    = phase_q;
		n_seen     = seen_q;
		n_dot      = dot_q;
		n_failed   = failed_q;
		n_tok_cnt  = tok_cnt_q;
		n_sent_cnt = sent_cnt_q;
		c_app      = 1'b0;
		c_done     = 1'b0;
		c_proc     = 1'b1;
		c_err      = ERR_NONE;
		c_cont     = 1'b0;
		kind_c     = kind_q;
		c_tok_rep  = tok_cnt_q;
		c_sent_rep = sent_cnt_q;

		if (failed_q) begin
			c_proc = 1'b0;
		end else begin
			if (dot_q) begin
				n_dot = 1'b0;
				if (c.closer) begin
					n_sent_cnt = n_sent_cnt + COUNT_BITS'(1);
				end
			end

			case (phase_q)
				PH_FIRST: begin
					c_proc = 1'b0;
					if (seen_q && c.comma) begin
						n_phase = PH_SECOND;
						n_seen  = 1'b0;
					end else if (!c.dig) begin
						c_err = ERR_BAD_DIGIT;
					end else begin
						n_seen = 1'b1;
						if (q_word.last) begin
							c_err = ERR_NO_COMMA;
						end
					end
				end
				PH_SECOND: begin
					if (c.rbrace) begin
						if (seen_q) begin
							n_phase = PH_OUT;
						end else begin
							c_err = ERR_BAD_DIGIT;
						end
					end else begin
						c_proc = 1'b0;
						if (!c.dig) begin
							c_err = ERR_BAD_DIGIT;
						end else begin
							n_seen = 1'b1;
						end
					end
				end
				default: begin
					if (wildcard_q) begin
						if (c.wild) begin
							if (esc_q) begin
								n_esc = 1'b0;
								n_awd = 1'b0;
							end else if (c.dot) begin
								n_awd = 1'b1;
							end else if (c.bslash) begin
								n_esc = 1'b1;
							end else if (c.lbrace && awd_q) begin
								n_phase = PH_FIRST;
								n_seen  = 1'b0;
								c_proc  = 1'b0;
								if (q_word.last) begin
									c_err = ERR_NO_COMMA;
								end
							end
						end else begin
							n_awd = 1'b0;
						end
					end
				end
			endcase

			if (c_err != ERR_NONE) begin
				c_proc   = 1'b0;
				n_open   = 1'b0;
				n_kind   = KIND_GENERIC;
				n_failed = 1'b1;
			end

			if (c_proc) begin
				if (!open_q) begin
					if (c.alnum) begin
						n_open = 1'b1;
						c_app  = 1'b1;
						n_kind = c.dig ? KIND_INTEGER : KIND_GENERIC;
					end
				end else begin
					// an integer is reclassified by its first non-digit
					if (kind_q == KIND_INTEGER) begin
						if (c.comma || c.dot) begin
							kind_c = KIND_DECIMAL;
						end else if (c.colon) begin
							kind_c = KIND_TIME;
						end else if (!c.dig) begin
							kind_c = KIND_GENERIC;
						end
					end
					case (kind_c)
						KIND_DECIMAL: c_cont = c.dig || c.dot || c.comma;
						KIND_TIME:    c_cont = c.dig || c.colon;
						default:      c_cont = c.alnum || c.gen_punct;
					endcase
					n_kind = kind_c;
					if (c_cont) begin
						c_app = 1'b1;
					end else begin
						c_done = 1'b1;
					end
				end
				if (c_done) begin
					c_tok_rep  = n_tok_cnt;
					c_sent_rep = n_sent_cnt;
					n_tok_cnt  = n_tok_cnt + COUNT_BITS'(1);
					n_open     = 1'b0;
					n_kind     = KIND_GENERIC;
				end
				if (!wildcard_q) begin
					if (c.dot && !q_word.last) begin
						n_dot = 1'b1;
					end else if (c.bang_q) begin
						n_sent_cnt = n_sent_cnt + COUNT_BITS'(1);
					end
				end
			end

			if (q_word.last && n_open) begin
				c_done     = 1'b1;
				c_tok_rep  = n_tok_cnt;
				c_sent_rep = n_sent_cnt;
				n_tok_cnt  = n_tok_cnt + COUNT_BITS'(1);
			end
		end

		if (!c_done) begin
			c_tok_rep  = n_tok_cnt;
			c_sent_rep = n_sent_cnt;
		end

		if (q_word.last) begin
			n_open   = 1'b0;
			n_kind   = KIND_GENERIC;
			n_esc    = 1'b0;
			n_awd    = 1'b0;
			n_phase  = PH_OUT;
			n_seen   = 1'b0;
			n_dot    = 1'b0;
			n_failed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wildcard_q  <= 1'b0;
			paragraph_q <= '0;
			open_q      <= 1'b0;
			kind_q      <= KIND_GENERIC;
			esc_q       <= 1'b0;
			awd_q       <= 1'b0;
			phase_q     <= PH_OUT;
			seen_q      <= 1'b0;
			dot_q       <= 1'b0;
			failed_q    <= 1'b0;
			tok_cnt_q   <= '0;
			sent_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_WILDCARD:  wildcard_q  <= cfg_data[0];
					CFG_PARAGRAPH: paragraph_q <= cfg_data;
					default:       ;
				endcase
			end
			if (q_pop) begin
				open_q      <= n_open;
				kind_q      <= n_kind;
				esc_q       <= n_esc;
				awd_q       <= n_awd;
				phase_q     <= n_phase;
				seen_q      <= n_seen;
				dot_q       <= n_dot;
				failed_q    <= n_failed;
				tok_cnt_q   <= n_tok_cnt;
				sent_cnt_q  <= n_sent_cnt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_word.data;
			app_q  <= c_app;
			done_q <= c_done;
			tok_q  <= 32'(c_tok_rep);
			sent_q <= 32'(c_sent_rep);
			para_q <= paragraph_q;
			err_q  <= c_err;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = byte_q;
	assign appended        = app_q;
	assign token_done      = done_q;
	assign token_number    = tok_q;
	assign sentence_number = sent_q;
	assign paragraph_out   = para_q;
	assign error_code      = err_q;

endmodule

`default_nettype wire

/* rtl/text_word_tokenizer.sv */
`default_nettype none

// Word tokenizer for Latin text, one byte per word on the input channel and
// one result word per input byte on the output channel. Throughput is one byte
// per clock sustained while the output is not stalled; a byte taken on the
// input is written into the queue, then loaded into the output register when
// the back end pops it, held while stalled. The figure is set by the
// per-byte token/sentence/quantifier update in the back end, which reads and
// writes its state once per byte. The front classifies each byte and pushes
// it into a four-deep queue, so input and output stall independently; the
// output is a register that keeps taking bytes while a result is not stalled.
// Config (wildcard_mode at index 0, paragraph_number at index 1) may only be
// written while no byte is in flight. Token and sentence counts are COUNT_BITS
// wide, wrap, and are reported in their low 32 bits.

module text_word_tokenizer import twt_pkg::*; #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// config write port
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     last_byte,
	// output channel
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic                          appended,
	output logic                          token_done,
	output logic [31:0]                   token_number,
	output logic [31:0]                   sentence_number,
	output logic [31:0]                   paragraph_out,
	output logic [1:0]                    error_code
);

	logic      q_full, q_empty, q_push, q_pop;
	twt_word_t push_word, pop_word;

	// front: handshake and byte classes
	twt_front u_front (
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (q_push),
		.push_word (push_word)
	);

	// decouples input acceptance from output stalls
	twt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_word  (pop_word),
		.empty     (q_empty)
	);

	// back: token state, counters, output register
	twt_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_empty         (q_empty),
		.q_word          (pop_word),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.appended        (appended),
		.token_done      (token_done),
		.token_number    (token_number),
		.sentence_number (sentence_number),
		.paragraph_out   (paragraph_out),
		.error_code      (error_code)
	);

endmodule

`default_nettype wire

/* rtl/twt_checker.sv */
`default_nettype none

module twt_checker import twt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        appended,
	input wire logic        token_done,
	input wire logic [31:0] token_number,
	input wire logic [1:0]  error_code
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(token_number))
		else $error("result changed while stalled");

	// only the defined error codes show up
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_NO_COMMA)
		else $error("undefined error code");

	// an aborted string drops its token
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !appended && !token_done)
		else $error("token activity on a quantifier error");

endmodule

bind text_word_tokenizer twt_checker u_twt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.appended     (appended),
	.token_done   (token_done),
	.token_number (token_number),
	.error_code   (error_code)
);

`default_nettype wire

/* verif/tokenizer_checker.sv */
`timescale 1ns / 100ps

module tokenizer_checker import twt_pkg::*; #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [7:0]               in_byte,
	input  logic                     last_byte,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [7:0]               out_byte,
	input  logic                     appended,
	input  logic                     token_done,
	input  logic [31:0]              token_number,
	input  logic [31:0]              sentence_number,
	input  logic [31:0]              paragraph_out,
	input  logic [1:0]               error_code,
	output int                       mismatches,
	output int                       words_pending,
	output int                       words_checked,
	output int                       tokens_seen,
	output int                       aborts_seen
);

	typedef enum logic [1:0] {KIND_GENERIC, KIND_INTEGER, KIND_DECIMAL, KIND_TIME} token_kind_t;
	typedef enum logic [1:0] {QUANT_NONE, QUANT_FIRST, QUANT_SECOND} quant_phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        appended;
		logic        done;
		logic [31:0] token_no;
		logic [31:0] sentence_no;
		logic [31:0] paragraph;
		logic [1:0]  err;
	} token_word_t;

	// model configuration
	logic        wildcard_on;
	logic [31:0] paragraph_reg;

	// model per-string state
	logic         in_token;
	token_kind_t  kind;
	logic         escape_open;
	logic         wild_dot;
	quant_phase_t quant;
	logic         quant_digit;
	logic         dot_wait;
	logic         aborted;

	// model counters
	logic [COUNT_BITS-1:0] token_cnt;
	logic [COUNT_BITS-1:0] sentence_cnt;

	token_word_t expected_words[$];

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return is_digit(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic void clear_string_state();
		in_token    = 1'b0;
		kind        = KIND_GENERIC;
		escape_open = 1'b0;
		wild_dot    = 1'b0;
		quant       = QUANT_NONE;
		quant_digit = 1'b0;
		dot_wait    = 1'b0;
		aborted     = 1'b0;
	endfunction

	// Next-state and result for one byte.
	function automatic token_word_t tokenize_byte(input logic [7:0] b, input logic last);
		token_word_t           r;
		logic                  app, done, proc;
		logic [1:0]            err;
		logic [COUNT_BITS-1:0] tok_rep, sent_rep;
		app      = 1'b0;
		done     = 1'b0;
		proc     = 1'b1;
		err      = ERR_NONE;
		tok_rep  = token_cnt;
		sent_rep = '0;

		if (aborted) begin
			proc = 1'b0;
		end else begin
			if (dot_wait) begin
				dot_wait = 1'b0;
				if (b == CH_DQUOTE || b == CH_APOS || b == CH_RPAREN || b == CH_RBRACK ||
				    b == CH_RBRACE || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
					sentence_cnt = sentence_cnt + COUNT_BITS'(1);
			end

			if (quant == QUANT_FIRST) begin
				proc = 1'b0;
				if (quant_digit && b == CH_COMMA) begin
					quant       = QUANT_SECOND;
					quant_digit = 1'b0;
				end else if (!is_digit(b)) begin
					err = ERR_BAD_DIGIT;
				end else begin
					quant_digit = 1'b1;
					if (last)
						err = ERR_NO_COMMA;
				end
			end else if (quant == QUANT_SECOND) begin
				if (b == CH_RBRACE) begin
					if (quant_digit)
						quant = QUANT_NONE;
					else
						err = ERR_BAD_DIGIT;
				end else begin
					proc = 1'b0;
					if (!is_digit(b))
						err = ERR_BAD_DIGIT;
					else
						quant_digit = 1'b1;
				end
			end else if (wildcard_on) begin
				if (b == CH_DOT || b == CH_BSLASH || b == CH_STAR || b == CH_PLUS ||
				    b == CH_QMARK || b == CH_LBRACE) begin
					if (escape_open) begin
						escape_open = 1'b0;
						wild_dot    = 1'b0;
					end else if (b == CH_DOT) begin
						wild_dot = 1'b1;
					end else if (b == CH_BSLASH) begin
						escape_open = 1'b1;
					end else if (b == CH_LBRACE && wild_dot) begin
						quant       = QUANT_FIRST;
						quant_digit = 1'b0;
						proc        = 1'b0;
						if (last)
							err = ERR_NO_COMMA;
					end
				end else begin
					wild_dot = 1'b0;
				end
			end

			if (err != ERR_NONE) begin
				proc     = 1'b0;
				in_token = 1'b0;
				kind     = KIND_GENERIC;
				aborted  = 1'b1;
			end

			if (proc) begin
				if (!in_token) begin
					if (is_alnum(b)) begin
						in_token = 1'b1;
						app      = 1'b1;
						kind     = is_digit(b) ? KIND_INTEGER : KIND_GENERIC;
					end
				end else begin
					// an integer turns into another kind on its first non-digit
					if (kind == KIND_INTEGER) begin
						if (b == CH_COMMA || b == CH_DOT)
							kind = KIND_DECIMAL;
						else if (b == CH_COLON)
							kind = KIND_TIME;
						else if (!is_digit(b))
							kind = KIND_GENERIC;
					end
					case (kind)
						KIND_DECIMAL: app = is_digit(b) || b == CH_DOT || b == CH_COMMA;
						KIND_TIME:    app = is_digit(b) || b == CH_COLON;
						default:      app = is_alnum(b) || b == CH_AMP || b == CH_APOS ||
						                    b == CH_DASH || b == CH_UNDER;
					endcase
					done = !app;
				end
				if (done) begin
					tok_rep   = token_cnt;
					sent_rep  = sentence_cnt;
					token_cnt = token_cnt + COUNT_BITS'(1);
					in_token  = 1'b0;
					kind      = KIND_GENERIC;
				end
				if (!wildcard_on) begin
					if (b == CH_DOT && !last)
						dot_wait = 1'b1;
					else if (b == CH_BANG || b == CH_QMARK)
						sentence_cnt = sentence_cnt + COUNT_BITS'(1);
				end
			end

			// end of string flushes the open token
			if (last && in_token) begin
				done      = 1'b1;
				tok_rep   = token_cnt;
				sent_rep  = sentence_cnt;
				token_cnt = token_cnt + COUNT_BITS'(1);
			end
		end

		if (!done) begin
			tok_rep  = token_cnt;
			sent_rep = sentence_cnt;
		end
		if (last)
			clear_string_state();

		r.data        = b;
		r.appended    = app;
		r.done        = done;
		r.token_no    = 32'(tok_rep);
		r.sentence_no = 32'(sent_rep);
		r.paragraph   = paragraph_reg;
		r.err         = err;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
	                           input logic [31:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t: word %0d %s mismatch, expected %0h, got %0h",
			         $time, words_checked, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_word_t want;
		if (!arst_n) begin
			wildcard_on   = 1'b0;
			paragraph_reg = '0;
			clear_string_state();
			token_cnt     = '0;
			sentence_cnt  = '0;
			expected_words.delete();
			mismatches    = 0;
			words_pending = 0;
			words_checked = 0;
			tokens_seen   = 0;
			aborts_seen   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word out, byte %0h", $time, out_byte);
				end else begin
					want = expected_words.pop_front();
					check_field("out_byte", 32'(want.data), 32'(out_byte));
					check_field("appended", 32'(want.appended), 32'(appended));
					check_field("token_done", 32'(want.done), 32'(token_done));
					check_field("token_number", want.token_no, token_number);
					check_field("sentence_number", want.sentence_no, sentence_number);
					check_field("paragraph_out", want.paragraph, paragraph_out);
					check_field("error_code", 32'(want.err), 32'(error_code));
					words_checked++;
				end
			end
			if (cfg_write) begin
				if (cfg_index == CFG_WILDCARD)
					wildcard_on = cfg_data[0];
				else if (cfg_index == CFG_PARAGRAPH)
					paragraph_reg = cfg_data[31:0];
			end
			if (in_valid && !in_stall) begin
				want = tokenize_byte(in_byte, last_byte);
				if (want.done)
					tokens_seen++;
				if (want.err != ERR_NONE)
					aborts_seen++;
				expected_words = {expected_words, want};
			end
			words_pending = expected_words.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import twt_pkg::*;

	// generous limit for a slow correct run
	localparam int CYCLE_LIMIT = 400000;

	// kinds of text fragment the random strings are built from
	typedef enum int {
		FRAG_WORD, FRAG_NUMBER, FRAG_PUNCT, FRAG_SPACE,
		FRAG_SENTENCE, FRAG_WILD, FRAG_QUANT, FRAG_NOISE
	} text_frag_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [7:0]               in_byte;
	logic                     last_byte;
	logic                     out_valid;
	logic                     out_stall;
	logic [7:0]               out_byte;
	logic                     appended;
	logic                     token_done;
	logic [31:0]              token_number;
	logic [31:0]              sentence_number;
	logic [31:0]              paragraph_out;
	logic [1:0]               error_code;

	// checker results
	int mismatches;
	int words_pending;
	int words_checked;
	int tokens_seen;
	int aborts_seen;

	// stimulus control, shared between the sender and the receiver process
	int   sender_idle_pct;
	int   receiver_idle_pct;
	bit   hold_request;
	int   words_sent;
	int   cycle_count;

	logic [7:0] text_q[$];  // bytes of the string being built

	text_word_tokenizer dut (.*);

	tokenizer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d words still expected",
		         $time, cycle_count, words_pending);
		$display("** text_word_tokenizer: FAILED **");
		$finish;
	end

	// Receiver side. Stalls at random per the current idle rate; on a hold
	// request it stalls for a long stretch so the block's queue fills up and
	// the input side has to stall too.
	initial begin
		int hold_left;
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range("0", "9"));
	endfunction

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
	endfunction

	// appends one byte to the string being built
	function automatic void add_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// One word on the input channel. Called at a falling edge, returns at the
	// falling edge after the word was taken. Valid stays up between words
	// unless a random gap is inserted.
	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// Sends the built string, last flag on its final byte.
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// Drop valid and wait until every expected word has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Both registers, back to back; only called while the block is idle.
	// Upper data bits of the mode write are junk the block must ignore.
	task automatic set_config(input logic wild, input logic [31:0] para);
		cfg_write <= 1'b1;
		cfg_index <= CFG_WILDCARD;
		cfg_data  <= {31'($urandom), wild};
		@(negedge clk);
		cfg_index <= CFG_PARAGRAPH;
		cfg_data  <= para;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Random strings until about budget bytes went in. Mostly token-like text
	// (words, numbers, sentence ends, quantifiers), with some raw noise and
	// broken quantifiers mixed in.
	task automatic run_segment(input int budget);
		int         sent;
		int         sel;
		int         variant;
		text_frag_t frag;
		sent = 0;
		while (sent < budget) begin
			repeat ($urandom_range(1, 6)) begin
				sel  = $urandom_range(0, 9);
				frag = (sel > 7) ? FRAG_WORD : text_frag_t'(sel);
				case (frag)
					FRAG_WORD: begin
						repeat ($urandom_range(1, 5))
							add_byte($urandom_range(0, 3) ? rand_letter() : rand_digit());
					end
					FRAG_NUMBER: begin
						// digits, then the byte that decides decimal/time/generic
						repeat ($urandom_range(1, 3)) add_byte(rand_digit());
						case ($urandom_range(0, 3))
							0:       add_byte(CH_DOT);
							1:       add_byte(CH_COMMA);
							2:       add_byte(CH_COLON);
							default: add_byte(rand_letter());
						endcase
						repeat ($urandom_range(0, 3)) add_byte(rand_digit());
					end
					FRAG_PUNCT: begin
						case ($urandom_range(0, 3))
							0:       add_byte(CH_AMP);
							1:       add_byte(CH_APOS);
							2:       add_byte(CH_DASH);
							default: add_byte(CH_UNDER);
						endcase
					end
					FRAG_SPACE: begin
						add_byte($urandom_range(0, 1) ? CH_SPACE :
						         8'($urandom_range(CH_TAB, CH_CR)));
					end
					FRAG_SENTENCE: begin
						case ($urandom_range(0, 2))
							0:       add_byte(CH_DOT);
							1:       add_byte(CH_BANG);
							default: add_byte(CH_QMARK);
						endcase
						if ($urandom_range(0, 1)) begin
							case ($urandom_range(0, 5))
								0:       add_byte(CH_DQUOTE);
								1:       add_byte(CH_APOS);
								2:       add_byte(CH_RPAREN);
								3:       add_byte(CH_RBRACK);
								4:       add_byte(CH_RBRACE);
								default: add_byte(CH_SPACE);
							endcase
						end
					end
					FRAG_WILD: begin
						case ($urandom_range(0, 6))
							0:       add_byte(CH_DOT);
							1:       add_byte(CH_BSLASH);
							2:       add_byte(CH_STAR);
							3:       add_byte(CH_PLUS);
							4:       add_byte(CH_QMARK);
							5:       add_byte(CH_LBRACE);
							default: add_byte(CH_RBRACE);
						endcase
					end
					FRAG_QUANT: begin
						// half well formed .{n,m}; the rest cut short after the
						// first number or the comma, a bad first byte, or an
						// empty second number
						variant = $urandom_range(0, 7);
						add_byte(CH_DOT);
						add_byte(CH_LBRACE);
						if (variant == 6) begin
							case ($urandom_range(0, 2))
								0:       add_byte(CH_COMMA);
								1:       add_byte(CH_RBRACE);
								default: add_byte(8'($urandom));
							endcase
						end else begin
							repeat ($urandom_range(1, 2)) add_byte(rand_digit());
							if (variant != 4) begin
								add_byte(CH_COMMA);
								if (variant < 4) begin
									repeat ($urandom_range(1, 2)) add_byte(rand_digit());
									add_byte(CH_RBRACE);
								end else if (variant == 7) begin
									add_byte(CH_RBRACE);
								end
							end
						end
					end
					default: add_byte(8'($urandom));
				endcase
			end
			sent += text_q.size();
			send_text();
		end
	endtask

	initial begin
		int          phase;
		int          seg;
		logic [31:0] para;

		// every block input known from time zero
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = CFG_WILDCARD;
		cfg_data          = '0;
		in_valid          = 1'b0;
		in_byte           = '0;
		last_byte         = 1'b0;
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		hold_request      = 1'b0;
		words_sent        = 0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, plain mode: letter and digit extremes, decimal, time,
		// digit-started generic word, sentence marks, a dot before a space,
		// bytes above 127, zero and all-ones bytes, dot on the last byte.
		set_config(1'b0, 32'hFFFF_FFFF);
		push_text("Az 0.9 1:2 3_!");
		send_text();
		text_q = {CH_DOT, CH_SPACE, CH_QMARK, 8'hFF, 8'h80, 8'h00, CH_DOT};
		send_text();
		wait_idle();

		// Directed, wildcard mode: good quantifier then escaped dot, bad
		// quantifier digit (rest of string ignored), string ending inside the
		// first quantifier number.
		set_config(1'b1, 32'h0);
		push_text(".{1,2}\\.");
		send_text();
		push_text(".{x");
		send_text();
		push_text(".{5");
		send_text();
		wait_idle();

		// Random part: three idle profiles, each walking both modes and the
		// paragraph extremes. Every segment ends with the sender paused until
		// all words have come back, which also makes the config writes legal.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 28;
					receiver_idle_pct = 65;
				end
				1: begin
					sender_idle_pct   = 65;
					receiver_idle_pct = 28;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				case (seg)
					0:       para = 32'h0;
					1:       para = 32'hFFFF_FFFF;
					2:       para = $urandom;
					default: para = 32'd1 << $urandom_range(0, 31);
				endcase
				set_config(seg % 2 == 1, para);
				// full-rate sender against a long receiver hold-off
				if (phase == 2 && seg == 0)
					hold_request = 1'b1;
				run_segment(105);
				wait_idle();
			end
		end

		repeat (16) @(negedge clk);

		$display("Run: %0d words in, %0d checked, %0d tokens finished, %0d quantifier aborts",
		         words_sent, words_checked, tokens_seen, aborts_seen);
		$display("Both modes, paragraph extremes, three idle profiles and a long output hold");
		if (mismatches == 0)
			$display("** text_word_tokenizer: PASSED **");
		else
			$display("** text_word_tokenizer: FAILED **");
		$finish;
	end

endmodule
